FILE: rtl/core/pnl_pkg.sv
// Shared types, codes and pin-mapping helpers for the parallel nibble link.
// No dependencies; imported by every module of the link.
package pnl_pkg;

    // configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int SPIN_LIMIT_W = 11 + 5;
    localparam int MAX_LEN_W   = 11;

    // parameter defaults
    localparam int DEF_COUNT_WIDTH = 11;
    localparam int DEF_SPIN_WIDTH  = 16;

    // register reset values
    localparam logic [SPIN_LIMIT_W-1:0] SPIN_LIMIT_RST = 16'd1000;
    localparam logic [MAX_LEN_W-1:0]    MAX_LEN_RST    = 11'd1500;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK_RUNNING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 2'd2;

    // request opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_EOF  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_DOWN    = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // end of frame flips these lines of the last low nibble
    localparam logic [4:0] PIN_EOF_FLIP = 5'h17;
    // peer end marker: upper status lines inverted against the last sample
    localparam logic [4:0] MARKER_FLIP  = 5'h17;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_TX_HI = 5'b00010,
        PH_TX_LO = 5'b00100,
        PH_RX_LO = 5'b01000,
        PH_RX_HI = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] send_byte;
        logic [7:0] status_pins;
    } item_t;

    typedef struct packed {
        logic [4:0] data_pins;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       rx_frame_end;
        logic       rx_overflow;
        logic       tx_busy;
        logic [1:0] status_code;
    } result_t;

    typedef struct packed {
        logic                    link_running;
        logic [SPIN_LIMIT_W-1:0] spin_limit;
        logic [MAX_LEN_W-1:0]    max_frame_len;
    } cfg_t;

    // high nibble with our strobe set
    function automatic logic [4:0] tx_hi_pins(input logic [7:0] b);
        return {b[7], 1'b1, b[6:4]};
    endfunction

    // low nibble, strobe clear
    function automatic logic [4:0] tx_lo_pins(input logic [7:0] b);
        return {b[3], 1'b0, b[2:0]};
    endfunction

    // rebuild a byte from the two status samples (bit 7 is inverted on the cable)
    function automatic logic [7:0] rx_assemble(input logic [7:0] f, input logic [7:0] s);
        return {~f[7], f[5:3], ~s[7], s[5:3]};
    endfunction

endpackage

FILE: rtl/core/pnl_cfg.sv
// Configuration registers of the parallel nibble link.
// Depends on pnl_pkg for register indexes, widths and reset values.
module pnl_cfg
    import pnl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_LINK_RUNNING:  cfg_next.link_running  = cfg_data[0];
                REG_SPIN_LIMIT:    cfg_next.spin_limit    = cfg_data[SPIN_LIMIT_W-1:0];
                REG_MAX_FRAME_LEN: cfg_next.max_frame_len = cfg_data[MAX_LEN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_running  <= 1'b0;
            cfg_reg.spin_limit    <= SPIN_LIMIT_RST;
            cfg_reg.max_frame_len <= MAX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/pnl_in_reg.sv
// Input register stage: holds one accepted request for the step logic.
// Depends on pnl_pkg for the request type.
module pnl_in_reg
    import pnl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t item_in,
    input  logic  advance,
    output logic  item_valid,
    output item_t item_q
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // free when empty or when the held request moves on this cycle
    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_q     = item_reg;

endmodule

FILE: rtl/core/pnl_step.sv
// Link state and per-request update: transmit handshake, receive assembly, timeouts.
// Depends on pnl_pkg for phase codes, request/result types and pin helpers.
module pnl_step
    import pnl_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int SPIN_WIDTH  = DEF_SPIN_WIDTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CMP_W = (COUNT_WIDTH > MAX_LEN_W) ? COUNT_WIDTH : MAX_LEN_W;

    phase_t                 phase_reg,   phase_next;
    logic [SPIN_WIDTH-1:0]  spin_reg,    spin_next;
    logic [7:0]             first_reg,   first_next;
    logic [7:0]             second_reg,  second_next;
    logic [COUNT_WIDTH-1:0] count_reg,   count_next;
    logic [7:0]             pending_reg, pending_next;
    logic [4:0]             pins_reg,    pins_next;

    logic                   strobe;
    logic                   spin_out;
    logic [SPIN_WIDTH-1:0]  spin_dec;
    logic [SPIN_WIDTH-1:0]  spin_load;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   rxv;
    logic [7:0]             rxd;
    logic                   fend;
    logic                   ovf;
    logic [1:0]             status;

    // spin counter helpers
    assign strobe    = item.status_pins[6];
    assign spin_out  = spin_reg <= SPIN_WIDTH'(1);
    assign spin_dec  = spin_out ? '0 : spin_reg - SPIN_WIDTH'(1);
    assign spin_load = SPIN_WIDTH'(cfg.spin_limit);
    assign count_inc = count_reg + COUNT_WIDTH'(1);

    // next state and result for the held request
    always_comb
    begin
        phase_next   = phase_reg;
        spin_next    = spin_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        pins_next    = pins_reg;
        rxv          = 1'b0;
        rxd          = 8'd0;
        fend         = 1'b0;
        ovf          = 1'b0;
        status       = ST_OK;

        if (item.opcode inside {OP_SEND, OP_EOF})
        begin
            // send side requests
            if (!cfg.link_running)
            begin
                status = ST_DOWN;
            end
            else if (phase_reg != PH_IDLE)
            begin
                status = ST_BUSY;
            end
            else if (item.opcode == OP_SEND)
            begin
                pending_next = item.send_byte;
                pins_next    = tx_hi_pins(item.send_byte);
                spin_next    = spin_load;
                phase_next   = PH_TX_HI;
            end
            else
            begin
                pins_next = tx_lo_pins(pending_reg) ^ PIN_EOF_FLIP;
            end
        end
        else if (item.opcode == OP_TICK)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    // peer strobe starts a received byte
                    if (cfg.link_running && strobe)
                    begin
                        first_next = item.status_pins;
                        pins_next  = 5'h08;
                        spin_next  = spin_load;
                        phase_next = PH_RX_LO;
                    end
                end
                PH_TX_HI:
                begin
                    // wait for the peer ack to rise
                    if (strobe || spin_out)
                    begin
                        if (!strobe)
                        begin
                            status = ST_TIMEOUT;
                        end
                        pins_next  = tx_lo_pins(pending_reg);
                        spin_next  = spin_load;
                        phase_next = PH_TX_LO;
                    end
                    else
                    begin
                        spin_next = spin_dec;
                    end
                end
                PH_TX_LO:
                begin
                    // wait for the peer ack to fall
                    if (!strobe)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (spin_out)
                    begin
                        status     = ST_TIMEOUT;
                        spin_next  = '0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        spin_next = spin_dec;
                    end
                end
                PH_RX_LO:
                begin
                    // strobe falls: second nibble sampled, byte complete
                    if (!strobe)
                    begin
                        second_next = item.status_pins;
                        pins_next   = 5'h00;
                        if (CMP_W'(count_inc) >= CMP_W'(cfg.max_frame_len))
                        begin
                            count_next = '0;
                            ovf        = 1'b1;
                        end
                        else
                        begin
                            count_next = count_inc;
                            rxv        = 1'b1;
                            rxd        = rx_assemble(first_reg, item.status_pins);
                        end
                        spin_next  = spin_load;
                        phase_next = PH_RX_HI;
                    end
                    else if (spin_out)
                    begin
                        spin_next  = '0;
                        pins_next  = 5'h00;
                        fend       = 1'b1;
                        status     = ST_TIMEOUT;
                        count_next = '0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        spin_next = spin_dec;
                    end
                end
                PH_RX_HI:
                begin
                    // next byte, timeout or end marker
                    if (strobe)
                    begin
                        first_next = item.status_pins;
                        pins_next  = 5'h08;
                        spin_next  = spin_load;
                        phase_next = PH_RX_LO;
                    end
                    else if (spin_out)
                    begin
                        spin_next  = '0;
                        pins_next  = 5'h00;
                        fend       = 1'b1;
                        status     = ST_TIMEOUT;
                        count_next = '0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        spin_next = spin_dec;
                        if ((item.status_pins[7:3] ^ MARKER_FLIP) == second_reg[7:3])
                        begin
                            pins_next  = 5'h00;
                            fend       = 1'b1;
                            count_next = '0;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // state registers advance only when the request is handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            spin_reg    <= '0;
            first_reg   <= 8'd0;
            second_reg  <= 8'd0;
            count_reg   <= '0;
            pending_reg <= 8'd0;
            pins_reg    <= 5'd0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            spin_reg    <= spin_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            pins_reg    <= pins_next;
        end
    end

    // result of this request
    always_comb
    begin
        res.data_pins    = pins_next;
        res.rx_valid     = rxv;
        res.rx_data      = rxd;
        res.rx_frame_end = fend;
        res.rx_overflow  = ovf;
        res.tx_busy      = (phase_next == PH_TX_HI) || (phase_next == PH_TX_LO);
        res.status_code  = status;
    end

endmodule

FILE: rtl/core/pnl_out_reg.sv
// Result register: holds one result until the consumer takes it.
// Depends on pnl_pkg for the result type.
module pnl_out_reg
    import pnl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res_in,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_q
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // load when empty or when the current result leaves this cycle
    assign advance = res_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_q     = res_reg;

endmodule

FILE: rtl/core/parallel_nibble_link.sv
// Parallel nibble link: byte transfer over a crossed parallel cable, one request per cycle
// while the result register is not held back by out_ready; the step logic is one pass
// between two registers, the input register and the result register.
// Reset (rst_n, async, active low): link down, phase idle, counters and pins zero,
// spin limit 1000, max frame length 1500; no clearing pass.
// Depends on pnl_pkg, pnl_cfg, pnl_in_reg, pnl_step, pnl_out_reg.
module parallel_nibble_link
    import pnl_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int SPIN_WIDTH  = DEF_SPIN_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [7:0]            send_byte,
    input  logic [7:0]            status_pins,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [4:0]            data_pins,
    output logic                  rx_valid,
    output logic [7:0]            rx_data,
    output logic                  rx_frame_end,
    output logic                  rx_overflow,
    output logic                  tx_busy,
    output logic [1:0]            status_code,
    // configuration
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_in;
    item_t   item_q;
    logic    item_valid;
    logic    advance;
    result_t res;
    result_t res_q;

    assign item_in.opcode      = opcode;
    assign item_in.send_byte   = send_byte;
    assign item_in.status_pins = status_pins;

    // configuration registers
    pnl_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // input register
    pnl_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_q     (item_q)
    );

    // link state and update
    pnl_step #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .SPIN_WIDTH  (SPIN_WIDTH)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_q),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    pnl_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res_in    (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_q     (res_q)
    );

    assign data_pins    = res_q.data_pins;
    assign rx_valid     = res_q.rx_valid;
    assign rx_data      = res_q.rx_data;
    assign rx_frame_end = res_q.rx_frame_end;
    assign rx_overflow  = res_q.rx_overflow;
    assign tx_busy      = res_q.tx_busy;
    assign status_code  = res_q.status_code;

    // input side stalls only behind a result that is held back
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a stalled result");

    // a received byte never comes with an overflow or an active transmit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rx_valid) |-> (!rx_overflow && !tx_busy))
        else $error("received byte with overflow or transmit busy");

    // a frame end releases the pins and leaves the transmitter idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rx_frame_end) |-> (data_pins == 5'd0 && !tx_busy && !rx_valid))
        else $error("frame end with pins driven or transmitter busy");

    // a refused request leaves the driven pins as they were
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res.status_code == ST_BUSY || res.status_code == ST_DOWN))
            |-> (res.data_pins == u_step.pins_reg))
        else $error("refused request changed the pins");

endmodule

FILE: verif/pnl_checker.sv
// Result checker for the parallel nibble link: keeps its own copy of the link state,
// predicts the result of every accepted request and compares the result channel.
// Depends on pnl_pkg; instantiated beside the block by tb_top.
module pnl_checker
    import pnl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [7:0]            send_byte,
    input  logic [7:0]            status_pins,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [4:0]            data_pins,
    input  logic                  rx_valid,
    input  logic [7:0]            rx_data,
    input  logic                  rx_frame_end,
    input  logic                  rx_overflow,
    input  logic                  tx_busy,
    input  logic [1:0]            status_code,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    expected_left,
    output int                    results_checked,
    output int                    bytes_received,
    output int                    frames_closed,
    output int                    overflows,
    output int                    timeouts
);

    // upper status lines compared against the last sample for the end marker
    localparam logic [7:0] MARKER_INV  = 8'hB8;
    localparam logic [7:0] MARKER_MASK = 8'hF8;

    // register copies
    logic                    link_up;
    logic [SPIN_LIMIT_W-1:0] spin_reload;
    logic [MAX_LEN_W-1:0]    frame_max;

    // link state copy
    phase_t                     link_phase;
    logic [DEF_SPIN_WIDTH-1:0]  spin_left;
    logic [7:0]                 first_smp;
    logic [7:0]                 second_smp;
    logic [DEF_COUNT_WIDTH-1:0] rx_cnt;
    logic [7:0]                 tx_byte;
    logic [4:0]                 pins;

    result_t expected_q[$];
    int      fails;
    int      n_checked;
    int      n_bytes;
    int      n_frames;
    int      n_ovf;
    int      n_tmo;

    // one handshake tick missed; true once the wait has run out
    function automatic logic spin_ran_out();
        if (spin_left <= 1)
        begin
            spin_left = '0;
            return 1'b1;
        end
        spin_left = spin_left - 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [4:0] low_nibble(input logic [7:0] b);
        return {b[3], 1'b0, b[2:0]};
    endfunction

    // peer strobe seen: take the first sample and acknowledge
    function automatic void open_rx_byte(input logic [7:0] s);
        first_smp  = s;
        pins       = 5'b01000;
        spin_left  = spin_reload;
        link_phase = PH_RX_LO;
    endfunction

    function automatic void close_frame();
        pins       = '0;
        rx_cnt     = '0;
        link_phase = PH_IDLE;
    endfunction

    // advance the link copy by one request and return the expected result
    function automatic result_t predict_link_step(input item_t req);
        result_t    res;
        logic       strobe;
        logic [7:0] s;
        res    = '0;
        s      = req.status_pins;
        strobe = s[6];
        case (req.opcode)
            OP_SEND, OP_EOF:
            begin
                if (!link_up)
                    res.status_code = ST_DOWN;
                else if (link_phase != PH_IDLE)
                    res.status_code = ST_BUSY;
                else if (req.opcode == OP_SEND)
                begin
                    tx_byte    = req.send_byte;
                    pins       = {req.send_byte[7], 1'b1, req.send_byte[6:4]};
                    spin_left  = spin_reload;
                    link_phase = PH_TX_HI;
                end
                else
                    pins = low_nibble(tx_byte) ^ PIN_EOF_FLIP;
            end
            OP_TICK:
            begin
                case (link_phase)
                    PH_IDLE:
                    begin
                        if (link_up && strobe)
                            open_rx_byte(s);
                    end
                    PH_TX_HI:
                    begin
                        // high nibble waits for the peer line to rise
                        if (strobe || spin_ran_out())
                        begin
                            if (!strobe)
                                res.status_code = ST_TIMEOUT;
                            pins       = low_nibble(tx_byte);
                            spin_left  = spin_reload;
                            link_phase = PH_TX_LO;
                        end
                    end
                    PH_TX_LO:
                    begin
                        // low nibble waits for the peer line to fall
                        if (!strobe || spin_ran_out())
                        begin
                            if (strobe)
                                res.status_code = ST_TIMEOUT;
                            link_phase = PH_IDLE;
                        end
                    end
                    PH_RX_LO:
                    begin
                        if (!strobe)
                        begin
                            second_smp = s;
                            pins       = '0;
                            rx_cnt     = rx_cnt + 1'b1;
                            if (rx_cnt >= frame_max)
                            begin
                                rx_cnt          = '0;
                                res.rx_overflow = 1'b1;
                            end
                            else
                            begin
                                res.rx_valid = 1'b1;
                                res.rx_data  = {~first_smp[7], first_smp[5:3], ~s[7], s[5:3]};
                            end
                            spin_left  = spin_reload;
                            link_phase = PH_RX_HI;
                        end
                        else if (spin_ran_out())
                        begin
                            close_frame();
                            res.rx_frame_end = 1'b1;
                            res.status_code  = ST_TIMEOUT;
                        end
                    end
                    PH_RX_HI:
                    begin
                        if (strobe)
                            open_rx_byte(s);
                        else if (spin_ran_out())
                        begin
                            close_frame();
                            res.rx_frame_end = 1'b1;
                            res.status_code  = ST_TIMEOUT;
                        end
                        else if (((s ^ MARKER_INV) & MARKER_MASK) == (second_smp & MARKER_MASK))
                        begin
                            close_frame();
                            res.rx_frame_end = 1'b1;
                        end
                    end
                    default:
                        link_phase = PH_IDLE;
                endcase
            end
            default:
            begin
            end
        endcase
        res.data_pins = pins;
        res.tx_busy   = (link_phase == PH_TX_HI) || (link_phase == PH_TX_LO);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // watch config writes, requests and results
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t seen;
        result_t want;
        item_t   req;
        if (!rst_n)
        begin
            link_up     = 1'b0;
            spin_reload = SPIN_LIMIT_RST;
            frame_max   = MAX_LEN_RST;
            link_phase  = PH_IDLE;
            spin_left   = '0;
            first_smp   = '0;
            second_smp  = '0;
            rx_cnt      = '0;
            tx_byte     = '0;
            pins        = '0;
            expected_q.delete();
        end
        else
        begin
            // results first, so a request in the same cycle never matches itself
            if (out_valid && out_ready)
            begin
                seen.data_pins    = data_pins;
                seen.rx_valid     = rx_valid;
                seen.rx_data      = rx_data;
                seen.rx_frame_end = rx_frame_end;
                seen.rx_overflow  = rx_overflow;
                seen.tx_busy      = tx_busy;
                seen.status_code  = status_code;
                if (expected_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with no request pending, expected none, actual %h",
                             $time, seen);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("data_pins", 8'(want.data_pins), 8'(seen.data_pins));
                    check_field("rx_valid", 8'(want.rx_valid), 8'(seen.rx_valid));
                    check_field("rx_data", want.rx_data, seen.rx_data);
                    check_field("rx_frame_end", 8'(want.rx_frame_end),
                                8'(seen.rx_frame_end));
                    check_field("rx_overflow", 8'(want.rx_overflow), 8'(seen.rx_overflow));
                    check_field("tx_busy", 8'(want.tx_busy), 8'(seen.tx_busy));
                    check_field("status_code", 8'(want.status_code), 8'(seen.status_code));
                    n_checked++;
                    n_bytes  += int'(want.rx_valid);
                    n_frames += int'(want.rx_frame_end);
                    n_ovf    += int'(want.rx_overflow);
                    if (want.status_code == ST_TIMEOUT)
                        n_tmo++;
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_LINK_RUNNING:  link_up     = cfg_data[0];
                    REG_SPIN_LIMIT:    spin_reload = cfg_data[SPIN_LIMIT_W-1:0];
                    REG_MAX_FRAME_LEN: frame_max   = cfg_data[MAX_LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                req.opcode      = opcode;
                req.send_byte   = send_byte;
                req.status_pins = status_pins;
                expected_q.push_back(predict_link_step(req));
            end
        end
        fail_count      <= fails;
        expected_left   <= expected_q.size();
        results_checked <= n_checked;
        bytes_received  <= n_bytes;
        frames_closed   <= n_frames;
        overflows       <= n_ovf;
        timeouts        <= n_tmo;
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the parallel nibble link: clock, reset, register setup and
// request/result traffic with random idling; verdict from the checker's failure count.
// Depends on pnl_pkg, parallel_nibble_link and pnl_checker.
module tb_top;
    import pnl_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;
    localparam int HOLD_AFTER  = 250;

    // opcode with no function
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            opcode;
    logic [7:0]            send_byte;
    logic [7:0]            status_pins;
    logic                  out_valid;
    logic                  out_ready;
    logic [4:0]            data_pins;
    logic                  rx_valid;
    logic [7:0]            rx_data;
    logic                  rx_frame_end;
    logic                  rx_overflow;
    logic                  tx_busy;
    logic [1:0]            status_code;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int expected_left;
    int results_checked;
    int bytes_received;
    int frames_closed;
    int overflows;
    int timeouts;

    item_t             stim_q[$];
    logic [15:0]       cur_spin;
    bit                no_idle;

    parallel_nibble_link i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .send_byte    (send_byte),
        .status_pins  (status_pins),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_pins    (data_pins),
        .rx_valid     (rx_valid),
        .rx_data      (rx_data),
        .rx_frame_end (rx_frame_end),
        .rx_overflow  (rx_overflow),
        .tx_busy      (tx_busy),
        .status_code  (status_code),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pnl_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .send_byte       (send_byte),
        .status_pins     (status_pins),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_pins       (data_pins),
        .rx_valid        (rx_valid),
        .rx_data         (rx_data),
        .rx_frame_end    (rx_frame_end),
        .rx_overflow     (rx_overflow),
        .tx_busy         (tx_busy),
        .status_code     (status_code),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked),
        .bytes_received  (bytes_received),
        .frames_closed   (frames_closed),
        .overflows       (overflows),
        .timeouts        (timeouts)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void queue_item(input logic [1:0] op, input logic [7:0] b,
                                       input logic [7:0] s);
        item_t it;
        it.opcode      = op;
        it.send_byte   = b;
        it.status_pins = s;
        stim_q.push_back(it);
    endfunction

    function automatic void queue_tick(input logic [7:0] s);
        queue_item(OP_TICK, 8'($urandom), s);
    endfunction

    function automatic logic [7:0] strobe_hi();
        return 8'($urandom) | 8'h40;
    endfunction

    function automatic logic [7:0] strobe_lo();
        return 8'($urandom) & 8'hBF;
    endfunction

    // low-strobe sample that does not look like the end marker
    function automatic logic [7:0] quiet_lo(input logic [7:0] last);
        logic [7:0] s;
        s = strobe_lo();
        if (((s ^ 8'hB8) & 8'hF8) == (last & 8'hF8))
            s = s ^ 8'h80;
        return s;
    endfunction

    // peer sends a frame of nbytes bytes, then a marker, a timeout or nothing
    function automatic void queue_rx_frame(input int nbytes);
        logic [7:0] last;
        int         pick;
        last = '0;
        for (int i = 0; i < nbytes; i++)
        begin
            queue_tick(strobe_hi());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) queue_tick(strobe_hi());
            last = strobe_lo();
            queue_tick(last);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) queue_tick(quiet_lo(last));
        end
        pick = $urandom_range(0, 9);
        if (pick < 7 || (pick < 9 && cur_spin > 8))
            queue_tick(((last ^ 8'hB8) & 8'hF8) | (8'($urandom) & 8'h07));
        else if (pick < 9)
            repeat ((cur_spin == 0) ? 1 : cur_spin) queue_tick(quiet_lo(last));
    endfunction

    // we send one byte while the peer acknowledges both nibbles, at times with an extra send or end of frame
    function automatic void queue_tx_byte();
        queue_item(OP_SEND, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) == 0)
            queue_item($urandom_range(0, 1) ? OP_SEND : OP_EOF, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 3)) queue_tick(strobe_lo());
        queue_tick(strobe_hi());
        repeat ($urandom_range(0, 3)) queue_tick(strobe_hi());
        queue_tick(strobe_lo());
        if ($urandom_range(0, 3) == 0)
            queue_item(OP_EOF, 8'($urandom), 8'($urandom));
    endfunction

    // one request, with an optional idle burst in front
    task automatic send_request(input item_t it);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= it.opcode;
        send_byte   <= it.send_byte;
        status_pins <= it.status_pins;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic run_batch();
        while (stim_q.size() != 0)
            send_request(stim_q.pop_front());
        in_valid <= 1'b0;
    endtask

    // mostly well-formed transfers with random content, the rest noise
    task automatic run_random(input int count);
        int pick;
        while (stim_q.size() < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                queue_rx_frame(($urandom_range(0, 4) == 0) ? $urandom_range(5, 12)
                                                            : $urandom_range(1, 4));
            else if (pick < 15)
                queue_tx_byte();
            else
                repeat ($urandom_range(1, 4))
                    queue_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        end
        run_batch();
    endtask

    // register writes once every expected result is back
    task automatic configure(input logic up, input logic [15:0] spin, input logic [10:0] len);
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (3) @(posedge clk);
        cur_spin     = spin;
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_LINK_RUNNING;
        cfg_data     <= CFG_DATA_W'(up);
        @(posedge clk);
        cfg_index    <= REG_SPIN_LIMIT;
        cfg_data     <= spin;
        @(posedge clk);
        cfg_index    <= REG_MAX_FRAME_LEN;
        cfg_data     <= CFG_DATA_W'(len);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin : result_sink
        int stall_left;
        int taken;
        bit long_hold_done;
        stall_left     = 0;
        taken          = 0;
        long_hold_done = 1'b0;
        out_ready      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (!long_hold_done && taken >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            else if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no traffic
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_TICK;
        send_byte    = '0;
        status_pins  = '0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_LINK_RUNNING;
        cfg_data     = '0;
        no_idle      = 1'b0;
        cur_spin     = SPIN_LIMIT_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // link down after reset: sends refused, strobe ignored, unused opcode
        queue_item(OP_SEND, 8'hFF, 8'h00);
        queue_item(OP_EOF, 8'h00, 8'hFF);
        queue_tick(8'h40);
        queue_item(OP_SPARE, 8'hFF, 8'hFF);
        run_batch();

        configure(1'b1, 16'd3, 11'd2);
        // end of frame before any byte, then a clean send and a refused one
        queue_item(OP_EOF, 8'h00, 8'h00);
        queue_item(OP_SEND, 8'h00, 8'hFF);
        queue_item(OP_SEND, 8'hA5, 8'h00);
        queue_tick(8'h40);
        queue_tick(8'h00);
        // send that times out on both nibbles, then end of frame
        queue_item(OP_SEND, 8'hFF, 8'h00);
        repeat (3) queue_tick(8'h00);
        repeat (3) queue_tick(8'h40);
        queue_item(OP_EOF, 8'hFF, 8'h00);
        // two received bytes, the second overflows, then the end marker
        queue_tick(8'hFF);
        queue_tick(8'hBF);
        queue_tick(8'h40);
        queue_tick(8'h00);
        queue_tick(8'hB8);
        // receive timeout while waiting for the low nibble
        repeat (4) queue_tick(8'h40);
        run_batch();

        configure(1'b1, SPIN_LIMIT_RST, MAX_LEN_RST);
        run_random(150);
        configure(1'b1, 16'd1, 11'd1);
        run_random(100);
        configure(1'b1, 16'd65535, 11'd2047);
        run_random(100);
        configure(1'b1, 16'd0, 11'd5);
        run_random(100);
        configure(1'b0, 16'd4, 11'd3);
        run_random(50);
        configure(1'b1, 16'd3, 11'd4);
        no_idle = 1'b1;
        run_random(200);

        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (4) @(posedge clk);
        $display("Checked %0d results: %0d bytes received, %0d frames closed,",
                 results_checked, bytes_received, frames_closed);
        $display("%0d overflows, %0d handshake timeouts; link up and down, spin 0..65535",
                 overflows, timeouts);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pnl_pkg.sv
rtl/core/pnl_cfg.sv
rtl/core/pnl_in_reg.sv
rtl/core/pnl_step.sv
rtl/core/pnl_out_reg.sv
rtl/core/parallel_nibble_link.sv
verif/pnl_checker.sv
verif/tb_top.sv
